// ----- design/huffman_tree_walk_utf8_decoder_macros.svh -----
// Assertion macros for the Huffman tree-walk UTF-8 decoder.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef HUFFMAN_TREE_WALK_UTF8_DECODER_MACROS_SVH
`define HUFFMAN_TREE_WALK_UTF8_DECODER_MACROS_SVH

// same-cycle implication, off while reset is high
`define HWD_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("huffman decoder: same-cycle check failed");

// next-cycle implication, off while reset is high
`define HWD_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("huffman decoder: next-cycle check failed");

`endif

// ----- design/hwd_pkg.sv -----
// Shared types, constants and helpers for the Huffman tree-walk UTF-8 decoder.
// No dependencies; imported by every module of the block.
package hwd_pkg;

   localparam int unsigned NODE_COUNT_DEF = 1024;
   localparam int unsigned IDX_W          = 10;
   localparam int unsigned SYM_W          = 32;
   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned REQ_TDATA_W    = 64;

   // item kinds carried on req_tuser
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_BIT   = 1'b1;

   // UTF-8 lead-byte tests
   localparam logic [SYM_W-1:0] MASK_4B = 32'hF000_0000;
   localparam logic [SYM_W-1:0] PAT_4B  = 32'hF000_0000;
   localparam logic [SYM_W-1:0] MASK_3B = 32'hFFE0_0000;
   localparam logic [SYM_W-1:0] PAT_3B  = 32'h00E0_0000;
   localparam logic [SYM_W-1:0] MASK_2B = 32'hFFFF_C000;
   localparam logic [SYM_W-1:0] PAT_2B  = 32'h0000_C000;

   // one node table entry
   typedef struct packed {
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic [SYM_W-1:0] sym;
   } node_entry_type;

   // symbol handed from the walker to the byte emitter
   typedef struct packed {
      logic             valid;
      logic [SYM_W-1:0] sym;
      logic [1:0]       last_pos;  // index of the first (most significant) byte sent
   } sym_push_type;

   // emitter fill level seen by the walker
   typedef struct packed {
      logic [1:0] count;
   } emit_status_type;

   // byte count minus one, from the lead-byte mask tests
   function automatic logic [1:0] sym_last_pos(input logic [SYM_W-1:0] sym);
      logic [1:0] pos;
      priority if ((sym & MASK_4B) == PAT_4B) pos = 2'd3;
      else if ((sym & MASK_3B) == PAT_3B)     pos = 2'd2;
      else if ((sym & MASK_2B) == PAT_2B)     pos = 2'd1;
      else                                    pos = 2'd0;
      return pos;
   endfunction

endpackage

// ----- design/huffman_tree_walk_utf8_decoder.sv -----
// Huffman tree-walk decoder with UTF-8 leaf symbols. A req beat with tuser = 0 writes
// one node table entry; with tuser = 1 it carries one code bit that steps the cursor to
// the right (1) or left (0) child. When the node reached holds a nonzero symbol, its
// 1 to 4 bytes leave on rsp most significant first, tlast on the final byte, and the
// cursor returns to the root. One req beat is taken per cycle while req is not stalled:
// the current node's children sit in registers, so each bit needs a single read of the
// node memory, whose registered data is checked for a leaf in the following cycle, when
// the symbol is pushed into the emitter queue. Decoded symbols queue three deep in front
// of a one-byte-per-cycle output (while rsp_tready is high), so req stalls only when the
// queue could overflow (three symbols held, or two held with a leaf being queued), and
// while the states REF_READ and REF_WAIT read the new root entry back through the
// memory's one read port after a root register write.
`include "huffman_tree_walk_utf8_decoder_macros.svh"

module huffman_tree_walk_utf8_decoder
   import hwd_pkg::*;
#(
   parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [IDX_W-1:0]       csr_wr_data,  // root_node
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,    // node_index[9:0], left_child[19:10],
                                                // right_child[29:20], node_symbol[61:30],
                                                // code_bit[62], zero[63]
   input  logic                   req_tuser,    // mode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [BYTE_W-1:0]      rsp_tdata,    // out_byte[7:0]
   output logic                   rsp_tlast     // last_byte
);

   typedef enum logic [1:0] {REF_IDLE, REF_READ, REF_WAIT} refresh_state_type;

   refresh_state_type state_ff, state_in;
   logic [IDX_W-1:0]  root_ff,       root_in;
   logic [IDX_W-1:0]  cursor_ff,     cursor_in;
   logic              fresh_ff,      fresh_in;
   logic [IDX_W-1:0]  cur_left_ff,   cur_left_in;
   logic [IDX_W-1:0]  cur_right_ff,  cur_right_in;
   logic [IDX_W-1:0]  root_left_ff,  root_left_in;
   logic [IDX_W-1:0]  root_right_ff, root_right_in;

   logic             req_fire;
   logic             is_wr;
   logic             is_bit;
   logic             wr_in_range;
   logic [IDX_W-1:0] f_node_index;
   logic [IDX_W-1:0] f_left;
   logic [IDX_W-1:0] f_right;
   logic [SYM_W-1:0] f_symbol;
   logic             f_code_bit;
   node_entry_type   wr_entry;
   node_entry_type   rd_entry;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_idx;
   logic             leaf;
   logic [IDX_W-1:0] cursor_now;
   logic [IDX_W-1:0] now_left;
   logic [IDX_W-1:0] now_right;
   logic [IDX_W-1:0] child;
   sym_push_type     push;
   emit_status_type  emit_status;

   // unpack the req beat
   assign f_node_index = req_tdata[9:0];
   assign f_left       = req_tdata[19:10];
   assign f_right      = req_tdata[29:20];
   assign f_symbol     = req_tdata[61:30];
   assign f_code_bit   = req_tdata[62];
   assign wr_entry     = '{left: f_left, right: f_right, sym: f_symbol};

   assign req_fire    = req_tvalid && req_tready;
   assign is_wr       = req_fire && (req_tuser == MODE_WRITE);
   assign is_bit      = req_fire && (req_tuser == MODE_BIT);
   assign wr_in_range = (32'(f_node_index) < NODE_COUNT);

   // leaf check on the entry read for the previous bit
   assign leaf       = fresh_ff && (rd_entry.sym != '0);
   assign cursor_now = leaf ? root_ff : cursor_ff;

   // children of the node under the cursor this cycle
   always_comb begin
      priority if (leaf) begin
         now_left  = root_left_ff;
         now_right = root_right_ff;
      end else if (fresh_ff) begin
         now_left  = rd_entry.left;
         now_right = rd_entry.right;
      end else begin
         now_left  = cur_left_ff;
         now_right = cur_right_ff;
      end
   end

   assign child = f_code_bit ? now_right : now_left;

   // queue must still have room for this beat's leaf after any pending leaf
   assign req_tready = (state_ff == REF_IDLE)
                    && ((emit_status.count < 2'd2)
                        || ((emit_status.count == 2'd2) && !leaf));

   assign mem_rd_en  = is_bit || (state_ff == REF_READ);
   assign mem_rd_idx = (state_ff == REF_READ) ? root_ff : child;

   assign push = '{valid: leaf, sym: rd_entry.sym, last_pos: sym_last_pos(rd_entry.sym)};

   // next state of the walker
   always_comb begin
      state_in      = state_ff;
      root_in       = root_ff;
      cursor_in     = cursor_now;
      fresh_in      = is_bit;
      cur_left_in   = now_left;
      cur_right_in  = now_right;
      root_left_in  = root_left_ff;
      root_right_in = root_right_ff;

      // root entry reload after a root register write
      unique case (state_ff)
         REF_READ: state_in = REF_WAIT;
         REF_WAIT: begin
            state_in      = REF_IDLE;
            cur_left_in   = rd_entry.left;
            cur_right_in  = rd_entry.right;
            root_left_in  = rd_entry.left;
            root_right_in = rd_entry.right;
         end
         default: state_in = REF_IDLE;
      endcase

      // a table write keeps the cached child pairs coherent
      if (is_wr && wr_in_range && (f_node_index == cursor_now)) begin
         cur_left_in  = f_left;
         cur_right_in = f_right;
      end
      if (is_wr && wr_in_range && (f_node_index == root_ff)) begin
         root_left_in  = f_left;
         root_right_in = f_right;
      end

      if (is_bit) begin
         cursor_in = child;
      end

      if (csr_wr_en) begin
         state_in  = REF_READ;
         root_in   = csr_wr_data;
         cursor_in = csr_wr_data;
         fresh_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= REF_IDLE;
         root_ff   <= '0;
         cursor_ff <= '0;
         fresh_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         root_ff   <= root_in;
         cursor_ff <= cursor_in;
         fresh_ff  <= fresh_in;
      end
   end

   // cached child pairs, no reset needed
   always_ff @(posedge clock) begin
      cur_left_ff   <= cur_left_in;
      cur_right_ff  <= cur_right_in;
      root_left_ff  <= root_left_in;
      root_right_ff <= root_right_in;
   end

   hwd_node_mem #(
      .NODE_COUNT (NODE_COUNT)
   ) u_node_mem (
      .clock   (clock),
      .wr_en   (is_wr),
      .wr_idx  (f_node_index),
      .wr_data (wr_entry),
      .rd_en   (mem_rd_en),
      .rd_idx  (mem_rd_idx),
      .rd_data (rd_entry)
   );

   hwd_byte_emit u_byte_emit (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .status     (emit_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // checks
   `HWD_ASSERT_IMPL(a_no_queue_overflow, push.valid, emit_status.count != 2'd3)
   `HWD_ASSERT_NEXT(a_root_write_stalls_req, csr_wr_en, !req_tready)
   `HWD_ASSERT_NEXT(a_leaf_gives_beat, leaf, rsp_tvalid)

endmodule

// ----- design/hwd_node_mem.sv -----
// Node table memory: one write port, one registered read port.
// Indexes at or beyond NODE_COUNT are dropped on write and read as zero. Uses hwd_pkg.
module hwd_node_mem
   import hwd_pkg::*;
#(
   parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  node_entry_type   wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output node_entry_type   rd_data
);

   localparam int unsigned AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

   node_entry_type mem_ff [NODE_COUNT];
   node_entry_type rd_q_ff;
   logic           rd_ok_ff;
   logic           wr_ok;
   logic           rd_ok;

   assign wr_ok = (32'(wr_idx) < NODE_COUNT);
   assign rd_ok = (32'(rd_idx) < NODE_COUNT);

   // write port
   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem_ff[AW'(wr_idx)] <= wr_data;
      end
   end

   // registered read, range flag kept beside the data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff  <= mem_ff[AW'(rd_idx)];
         rd_ok_ff <= rd_ok;
      end
   end

   assign rd_data = rd_ok_ff ? rd_q_ff : '0;

endmodule

// ----- design/hwd_byte_emit.sv -----
// Byte emitter: three-symbol queue, sends each symbol most significant byte first.
// Receives symbols from the walker as sym_push_type; uses hwd_pkg.
module hwd_byte_emit
   import hwd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sym_push_type      push,
   output emit_status_type   status,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // out_byte[7:0]
   output logic              rsp_tlast    // last_byte
);

   localparam logic [1:0] Q_LAST = 2'd2;  // highest queue slot

   logic [SYM_W-1:0] q_sym_ff [3];
   logic [1:0]       q_pos_ff [3];
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       count_ff,  count_in;
   logic [1:0]       head_pos;
   logic             fire;
   logic             pop;

   // head of queue drives the result beat
   assign head_pos   = q_pos_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = q_sym_ff[rd_ptr_ff][{head_pos, 3'b000} +: BYTE_W];
   assign rsp_tlast  = (head_pos == 2'd0);
   assign fire       = rsp_tvalid && rsp_tready;
   assign pop        = fire && rsp_tlast;
   assign status     = '{count: count_ff};

   // pointer and fill-count next values, pointers wrap after the last slot
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_LAST) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == Q_LAST) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      unique case ({push.valid, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 2'd0;
         wr_ptr_ff <= 2'd0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload: load on push, count down the head byte position per beat
   always_ff @(posedge clock) begin
      if (push.valid) begin
         q_sym_ff[wr_ptr_ff] <= push.sym;
         q_pos_ff[wr_ptr_ff] <= push.last_pos;
      end
      if (fire && !rsp_tlast) begin
         q_pos_ff[rd_ptr_ff] <= head_pos - 2'd1;
      end
   end

endmodule

// ----- tb/huffman_decode_checker.sv -----
// Checker for the Huffman tree-walk UTF-8 decoder: mirrors node table, root and cursor
// from the observed csr and req beats, predicts the rsp byte stream and compares it.
// Depends on hwd_pkg for widths, item kinds and the UTF-8 lead-byte masks.
`timescale 1ns / 1ps

module huffman_decode_checker
   import hwd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [IDX_W-1:0]       csr_wr_data,  // root_node
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,    // node_index, left_child, right_child,
                                                // node_symbol, code_bit, zero pad
   input  logic                   req_tuser,    // mode
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [BYTE_W-1:0]      rsp_tdata,    // out_byte
   input  logic                   rsp_tlast,    // last_byte
   output int                     fail_count,
   output int                     bytes_owed
);

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } utf8_byte_type;

   node_entry_type   node_shadow [NODE_COUNT_DEF];
   logic [IDX_W-1:0] root_idx;
   logic [IDX_W-1:0] cursor_idx;
   utf8_byte_type    owed_bytes [$];
   int               errors = 0;

   assign fail_count = errors;

   // one tree step; a leaf queues its bytes MSB first and sends the cursor home
   task automatic walk_code_bit(input logic code_bit);
      node_entry_type   here;
      logic [SYM_W-1:0] sym;
      utf8_byte_type    b;
      int               nbytes;
      int               k;
      here       = node_shadow[cursor_idx];
      cursor_idx = code_bit ? here.right : here.left;
      sym        = node_shadow[cursor_idx].sym;
      if (sym != '0) begin
         if ((sym & MASK_4B) == PAT_4B)      nbytes = 4;
         else if ((sym & MASK_3B) == PAT_3B) nbytes = 3;
         else if ((sym & MASK_2B) == PAT_2B) nbytes = 2;
         else                                nbytes = 1;
         for (k = nbytes - 1; k >= 0; k--) begin
            b.data = sym[k*BYTE_W +: BYTE_W];
            b.last = (k == 0);
            owed_bytes.push_back(b);
         end
         cursor_idx = root_idx;
      end
   endtask

   always @(posedge clock) begin : monitor
      utf8_byte_type want;
      if (reset) begin
         root_idx   = '0;
         cursor_idx = '0;
         owed_bytes.delete();
      end else begin
         // compare outgoing bytes against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (owed_bytes.size() == 0) begin
               errors++;
               $display("%0t: unexpected rsp beat: byte %02h last %0d",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = owed_bytes.pop_front();
               if (want.data !== rsp_tdata || want.last !== rsp_tlast) begin
                  errors++;
                  $display("%0t: rsp mismatch: expected byte %02h last %0d, got byte %02h last %0d",
                           $time, want.data, want.last, rsp_tdata, rsp_tlast);
               end
            end
         end
         // root write also restarts the walk
         if (csr_wr_en) begin
            root_idx   = csr_wr_data;
            cursor_idx = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == MODE_WRITE)
               node_shadow[req_tdata[9:0]] = '{left:  req_tdata[19:10],
                                               right: req_tdata[29:20],
                                               sym:   req_tdata[61:30]};
            else
               walk_code_bit(req_tdata[62]);
         end
      end
      bytes_owed <= owed_bytes.size();
   end

endmodule

// ----- tb/huffman_tree_walk_utf8_decoder_tb.sv -----
// Testbench top for the Huffman tree-walk UTF-8 decoder: loads a directed tree and random
// code trees, walks them with bit streams under bursty req and stalled rsp traffic.
// Depends on hwd_pkg, the decoder RTL and huffman_decode_checker.
`timescale 1ns / 1ps

module huffman_tree_walk_utf8_decoder_tb;
   import hwd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [IDX_W-1:0]       csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   req_tuser   = MODE_WRITE;
   logic                   rsp_tready  = 1'b0;
   wire                    req_tready;
   wire                    rsp_tvalid;
   wire  [BYTE_W-1:0]      rsp_tdata;
   wire                    rsp_tlast;
   int                     fail_count;
   int                     bytes_owed;

   int cycle_count = 0;
   int burst_left  = 0;
   int stall_style = 0;
   int stall_cnt   = 0;

   // what has been loaded, and the tree now being decoded
   bit               written [NODE_COUNT_DEF];
   int               written_list [$];
   bit               in_tree [NODE_COUNT_DEF];
   int               tree_nodes [$];
   logic [IDX_W-1:0] tree_left  [NODE_COUNT_DEF];
   logic [IDX_W-1:0] tree_right [NODE_COUNT_DEF];
   logic [SYM_W-1:0] tree_sym   [NODE_COUNT_DEF];

   huffman_tree_walk_utf8_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   huffman_decode_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .bytes_owed  (bytes_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // rsp back-pressure: one of four styles (always ready, random, periodic, mostly ready), redrawn at random
   always @(posedge clock) begin
      stall_cnt++;
      if (stall_cnt % 64 == 0)
         stall_style = $urandom_range(0, 3);
      case (stall_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (stall_cnt % 4 == 0);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // one req beat; bursts of random length, random gaps between them
   task automatic send_beat(input logic mode, input logic [IDX_W-1:0] idx,
                            input logic [IDX_W-1:0] lc, input logic [IDX_W-1:0] rc,
                            input logic [SYM_W-1:0] sym, input logic cbit);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, cbit, sym, rc, lc, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_node(input int idx, input int lc, input int rc,
                             input logic [SYM_W-1:0] sym);
      send_beat(MODE_WRITE, IDX_W'(idx), IDX_W'(lc), IDX_W'(rc), sym,
                1'($urandom_range(0, 1)));
      if (!written[idx]) begin
         written[idx] = 1'b1;
         written_list.push_back(idx);
      end
   endtask

   // unused fields of a bit beat carry junk
   task automatic send_bit(input logic cbit);
      send_beat(MODE_BIT, IDX_W'($urandom_range(0, 1023)), IDX_W'($urandom_range(0, 1023)),
                IDX_W'($urandom_range(0, 1023)), $urandom, cbit);
   endtask

   // hold req off until every predicted byte is out, then wait extra spare cycles
   task automatic drain(input int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_root(input int root);
      drain(12);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= IDX_W'(root);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [SYM_W-1:0] pick_symbol();
      logic [SYM_W-1:0] corner_syms [13] = '{
         32'hFFFF_FFFF, 32'hF000_0000, 32'h00FF_FFFF, 32'h00E0_0000, 32'h0000_FFFF,
         32'h0000_C000, 32'h0000_0001, 32'h0000_00FF, 32'hE000_0000, 32'h01E0_0000,
         32'h0001_C000, 32'h0000_8000, 32'h7FFF_FF00};
      logic [SYM_W-1:0] r;
      logic [SYM_W-1:0] s;
      r = $urandom;
      case ($urandom_range(0, 5))
         0: s = PAT_4B | (r & ~MASK_4B);
         1: s = PAT_3B | (r & ~MASK_3B);
         2: s = PAT_2B | (r & ~MASK_2B);
         3: s = {24'h0, r[7:0]};
         4: s = r;
         default: s = corner_syms[$urandom_range(0, 12)];
      endcase
      if (s == '0)
         s = 32'h1;
      return s;
   endfunction

   function automatic int fresh_node();
      int x;
      do x = $urandom_range(0, NODE_COUNT_DEF - 1); while (in_tree[x]);
      in_tree[x] = 1'b1;
      tree_nodes.push_back(x);
      return x;
   endfunction

   // grow a random full binary tree by splitting leaves, then load it in random order;
   // leaves point back at the root so every reachable entry is loaded
   task automatic build_tree(input int root, input int n_leaves);
      int leaves [$];
      int order [$];
      int k;
      int p;
      int a;
      int b;
      int j;
      int tmp;
      foreach (in_tree[i]) in_tree[i] = 1'b0;
      tree_nodes.delete();
      in_tree[root] = 1'b1;
      tree_nodes.push_back(root);
      leaves.push_back(root);
      repeat (n_leaves - 1) begin
         k = $urandom_range(0, leaves.size() - 1);
         p = leaves[k];
         leaves.delete(k);
         a = fresh_node();
         b = fresh_node();
         tree_left[p]  = IDX_W'(a);
         tree_right[p] = IDX_W'(b);
         tree_sym[p]   = '0;
         leaves.push_back(a);
         leaves.push_back(b);
      end
      foreach (leaves[i]) begin
         tree_sym[leaves[i]]   = pick_symbol();
         tree_left[leaves[i]]  = IDX_W'(root);
         tree_right[leaves[i]] = IDX_W'(root);
      end
      // the root's own symbol is looked at only if a walk steps into the root through a child link
      if ($urandom_range(0, 3) == 0)
         tree_sym[root] = pick_symbol();
      order = tree_nodes;
      for (j = order.size() - 1; j > 0; j--) begin
         k = $urandom_range(0, j);
         tmp = order[j];
         order[j] = order[k];
         order[k] = tmp;
      end
      foreach (order[i])
         write_node(order[i], int'(tree_left[order[i]]), int'(tree_right[order[i]]),
                    tree_sym[order[i]]);
   endtask

   // stray write: mostly off the live tree, sometimes a new symbol on a tree node
   task automatic noise_write();
      int idx;
      logic [SYM_W-1:0] s;
      s = ($urandom_range(0, 1) == 0) ? '0 : pick_symbol();
      if ($urandom_range(0, 3) == 0) begin
         idx = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
         tree_sym[idx] = s;
         write_node(idx, int'(tree_left[idx]), int'(tree_right[idx]), s);
      end else begin
         do idx = $urandom_range(0, NODE_COUNT_DEF - 1); while (in_tree[idx]);
         write_node(idx, written_list[$urandom_range(0, written_list.size() - 1)],
                    written_list[$urandom_range(0, written_list.size() - 1)], s);
      end
   endtask

   task automatic run_phase(input int root, input int n_leaves, input int n_bits,
                            input bit pause_midway);
      int i;
      build_tree(root, n_leaves);
      set_root(root);
      for (i = 0; i < n_bits; i++) begin
         if (pause_midway && i == n_bits / 2)
            drain(0);
         if ($urandom_range(0, 9) == 0)
            noise_write();
         send_bit(1'($urandom_range(0, 1)));
      end
   endtask

   initial begin : stimulus
      logic directed_bits [9];
      directed_bits = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed tree: every byte count, near-miss lead patterns, index extremes,
      // and a root carrying a symbol that must be ignored
      write_node(0, 1023, 1, 32'h0000_00AA);
      write_node(1023, 0, 0, 32'hFFFF_FFFF);
      write_node(1, 2, 3, '0);
      write_node(2, 0, 0, 32'h0000_C000);
      write_node(3, 4, 5, '0);
      write_node(4, 0, 0, 32'hE000_0000);
      write_node(5, 0, 0, 32'h00FF_FFFF);
      set_root(0);
      foreach (directed_bits[i])
         send_bit(directed_bits[i]);

      // random trees, root extremes included; ending mid-walk tests the root reset
      run_phase(1023, 6, 40, 1'b0);
      run_phase($urandom_range(0, 1023), $urandom_range(2, 12), 40, 1'b1);
      run_phase($urandom_range(0, 1023), 40, 40, 1'b0);
      run_phase(0, $urandom_range(2, 12), 40, 1'b0);
      run_phase($urandom_range(0, 1023), $urandom_range(2, 12), 40, 1'b0);

      drain(24);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/hwd_pkg.sv
design/hwd_node_mem.sv
design/hwd_byte_emit.sv
design/huffman_tree_walk_utf8_decoder.sv
tb/huffman_decode_checker.sv
tb/huffman_tree_walk_utf8_decoder_tb.sv
